### rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define AST_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, active during reset too
`define AST_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/ucllf_pkg.sv
// constants, types and helper functions of the utf-8 cyrillic line formatter
`timescale 1ns / 1ps
`default_nettype none
package ucllf_pkg;

	localparam int SLOT_W = 5;
	localparam logic [SLOT_W-1:0] LINE_CHARS = 5'd16;
	localparam logic [SLOT_W-1:0] SLOT_MAX = 5'd31;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_LINE_MODE = 1'b0;

	localparam logic [1:0] LEAD_NONE = 2'd0;
	localparam logic [1:0] LEAD_D0 = 2'd1;
	localparam logic [1:0] LEAD_D1 = 2'd2;
	localparam logic [1:0] LEAD_OTHER = 2'd3;

	localparam logic [7:0] BYTE_ASCII_END = 8'h80;
	localparam logic [7:0] BYTE_LEAD_D0 = 8'hD0;
	localparam logic [7:0] BYTE_LEAD_D1 = 8'hD1;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef struct packed {
		logic hit;
		logic [7:0] code;
	} map_res_t;

	function automatic map_res_t map_pair(input logic [1:0] kind, input logic [7:0] b);
		map_res_t r;
		r.hit = 1'b0;
		r.code = b;
		case (kind)
			LEAD_D0: begin
				if (b >= 8'h90 && b <= 8'hBF) begin
					r.hit = 1'b1;
					r.code = b + 8'h30;
				end else if (b == 8'h81) begin
					r.hit = 1'b1;
					r.code = 8'hA8;
				end
			end
			LEAD_D1: begin
				if (b >= 8'h80 && b <= 8'h8F) begin
					r.hit = 1'b1;
					r.code = b + 8'h70;
				end else if (b == 8'h91) begin
					r.hit = 1'b1;
					r.code = 8'hB8;
				end
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_MAX) ? s : s + 1'b1;
	endfunction

endpackage
`default_nettype wire

### rtl/core/utf8_cyrillic_lcd_line_formatter.sv
// each input beat passes the input register, then the result register
// throughput: one input beat per cycle while in_stall is low; each beat gives at most one result beat
// a string end in line mode adds up to LINE_CHARS space beats, one per cycle from the
//   result register while out_stall is low, and the input stalls until the last of them is loaded
// reset: pipeline and pad counter empty, no lead byte pending, slot count 0, line mode on
`timescale 1ns / 1ps
`default_nettype none
module utf8_cyrillic_lcd_line_formatter import ucllf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               byte_valid,
	input  wire logic [7:0]         byte_in,
	input  wire logic               string_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              char_code,
	output logic                    line_done,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic               line_mode_q;
	logic               valid_s1;
	logic               byte_valid_s1;
	logic [7:0]         byte_s1;
	logic               end_s1;
	logic [1:0]         lead_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  pad_q;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               done_q;

	logic               out_free;
	logic               take_s1;
	logic               line_full;
	map_res_t           mr;
	logic               has_char;
	logic [7:0]         code;
	logic [1:0]         lead_n;
	logic [SLOT_W-1:0]  slot_n;
	logic [SLOT_W-1:0]  pad_cnt;
	logic               load_out;
	logic [7:0]         load_code;
	logic               load_done;
	logic [SLOT_W-1:0]  pad_n;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LINE_MODE) ? {{(PDATA_W-1){1'b0}}, line_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_MODE) begin
			line_mode_q <= pwdata[0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign take_s1 = valid_s1 && out_free && (pad_q == '0);
	assign in_stall = valid_s1 && !take_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_valid_s1 <= byte_valid;
			byte_s1 <= byte_in;
			end_s1 <= string_end;
		end
	end

	// decode of the held beat
	assign line_full = line_mode_q && (slot_q >= LINE_CHARS);
	assign mr = map_pair(lead_q, byte_s1);

	always_comb begin
		has_char = 1'b0;
		code = byte_s1;
		lead_n = lead_q;
		slot_n = slot_q;
		if (byte_valid_s1) begin
			if (lead_q != LEAD_NONE) begin
				has_char = mr.hit;
				code = mr.code;
				lead_n = LEAD_NONE;
				slot_n = slot_inc(slot_q);
			end else if (!line_full) begin
				if (byte_s1 < BYTE_ASCII_END) begin
					has_char = 1'b1;
					slot_n = slot_inc(slot_q);
				end else if (byte_s1 == BYTE_LEAD_D0) begin
					lead_n = LEAD_D0;
				end else if (byte_s1 == BYTE_LEAD_D1) begin
					lead_n = LEAD_D1;
				end else begin
					lead_n = LEAD_OTHER;
				end
			end
		end
		pad_cnt = (end_s1 && line_mode_q && slot_n < LINE_CHARS) ? LINE_CHARS - slot_n : '0;
	end

	// result register loading
	always_comb begin
		load_out = 1'b0;
		load_code = CHAR_SPACE;
		load_done = 1'b0;
		pad_n = pad_q;
		if (take_s1) begin
			if (has_char) begin
				load_out = 1'b1;
				load_code = code;
				load_done = end_s1 && (pad_cnt == '0);
				pad_n = pad_cnt;
			end else if (pad_cnt != '0) begin
				load_out = 1'b1;
				load_done = (pad_cnt == 5'd1);
				pad_n = pad_cnt - 1'b1;
			end
		end else if (pad_q != '0 && out_free) begin
			load_out = 1'b1;
			load_done = (pad_q == 5'd1);
			pad_n = pad_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= LEAD_NONE;
			slot_q <= '0;
			pad_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				lead_q <= end_s1 ? LEAD_NONE : lead_n;
				slot_q <= end_s1 ? '0 : slot_n;
			end
			pad_q <= pad_n;
			if (out_free) begin
				out_valid_q <= load_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= load_code;
			done_q <= load_done;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign line_done = done_q;

endmodule
`default_nettype wire

### rtl/core/ucllf_chk.sv
// port-level checker for the utf-8 cyrillic line formatter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ucllf_chk import ucllf_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [7:0]         char_code,
	input wire logic               line_done,
	input wire logic               pready
);

	// a stalled result beat holds
	`AST_RST(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(line_done), "result beat changed while stalled")

	// the input only stalls behind a pending result beat
	`AST_ALWAYS(a_stall_cause, clk, in_stall |-> out_valid, "input stalled with no result pending")

	// no result beat right after reset release
	`AST_RST(a_reset_empty, clk, arst_n, $past(!arst_n) |-> !out_valid, "result beat present after reset")

	// config port never waits
	`AST_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind utf8_cyrillic_lcd_line_formatter ucllf_chk u_ucllf_chk (.*);
`default_nettype wire
